// File: src/lbsg_pkg.sv
`default_nettype none

package lbsg_pkg;

  localparam int FRAME_SIDE_DEFAULT = 256;

  // The stamp window is a fixed 8x8 patch, offset three pixels up and left.
  localparam int PATCH_SIDE   = 8;
  localparam int PATCH_BITS   = 3;
  localparam int PATCH_HALF   = 3;
  localparam int PATCH_AREA   = PATCH_SIDE * PATCH_SIDE;
  localparam int CNT_W        = 2 * PATCH_BITS + 1;

  // Signed width of a window coordinate: an 8-bit centre plus the offset.
  localparam int COORD_W      = 10;

  localparam logic [6:0] EFF_CAP  = 7'd64;
  localparam logic [7:0] LUMA_MAX = 8'hFF;
  localparam logic [7:0] LUMA_MID = 8'd128;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STAMP = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETAIL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUIDANCE    = 2'd2;

  localparam logic [8:0] BASE_GAIN_RESET   = 9'd102;
  localparam logic [8:0] DETAIL_GAIN_RESET = 9'd153;
  localparam logic [9:0] GUIDANCE_RESET    = 10'd384;

  localparam logic [7:0] PATCH_WEIGHT [PATCH_AREA] = '{
    8'd16, 8'd32,  8'd48,  8'd64,  8'd64,  8'd48,  8'd32,  8'd16,
    8'd32, 8'd64,  8'd96,  8'd128, 8'd128, 8'd96,  8'd64,  8'd32,
    8'd48, 8'd96,  8'd144, 8'd192, 8'd192, 8'd144, 8'd96,  8'd48,
    8'd64, 8'd128, 8'd192, 8'd255, 8'd255, 8'd192, 8'd128, 8'd64,
    8'd64, 8'd128, 8'd192, 8'd255, 8'd255, 8'd192, 8'd128, 8'd64,
    8'd48, 8'd96,  8'd144, 8'd192, 8'd192, 8'd144, 8'd96,  8'd48,
    8'd32, 8'd64,  8'd96,  8'd128, 8'd128, 8'd96,  8'd64,  8'd32,
    8'd16, 8'd32,  8'd48,  8'd64,  8'd64,  8'd48,  8'd32,  8'd16
  };

  typedef struct packed {
    logic             load_item;
    logic             write_blend;
    logic             read_issue;
    logic             read_mul;
    logic             read_finish;
    logic             calc_eff;
    logic             stamp_issue;
    logic [CNT_W-1:0] cnt;
    logic             load_result;
  } lbsg_cmd_t;

  typedef struct packed {
    logic eff_zero;
    logic out_free;
  } lbsg_status_t;

endpackage

`default_nettype wire

// File: src/lbsg_item_if.sv
`default_nettype none

interface lbsg_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [15:0] pixel_index;
  logic [7:0] base_luma;
  logic [7:0] detail_luma;
  logic [7:0] strength;
  logic [7:0] pattern_amp;
  logic       sign_negative;
  logic [7:0] center_x;
  logic [7:0] center_y;

  modport source (
    output valid, command, pixel_index, base_luma, detail_luma, strength, pattern_amp,
           sign_negative, center_x, center_y,
    input  ready
  );
  modport sink (
    input  valid, command, pixel_index, base_luma, detail_luma, strength, pattern_amp,
           sign_negative, center_x, center_y,
    output ready
  );
endinterface

`default_nettype wire

// File: src/lbsg_result_if.sv
`default_nettype none

interface lbsg_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_luma;
  logic       stamp_applied;

  modport source (output valid, read_luma, stamp_applied, input ready);
  modport sink (input valid, read_luma, stamp_applied, output ready);
endinterface

`default_nettype wire

// File: src/lbsg_ram.sv
`default_nettype none

module lbsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/lbsg_ctrl.sv
`default_nettype none

module lbsg_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  input  wire logic [1:0]             item_command,
  output      logic                   item_ready,
  output      lbsg_pkg::lbsg_cmd_t    cmd,
  input  wire lbsg_pkg::lbsg_status_t status
);
  import lbsg_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_WR   = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_RMUL = 8'b0000_1000,
    S_RFIN = 8'b0001_0000,
    S_EFF  = 8'b0010_0000,
    S_ST   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    item_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          unique case (item_command)
            CMD_WRITE: state_next = S_WR;
            CMD_STAMP: state_next = S_EFF;
            CMD_READ:  state_next = S_RD;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_WR: begin
        cmd.write_blend = 1'b1;
        state_next      = S_DONE;
      end
      S_RD: begin
        cmd.read_issue = 1'b1;
        state_next     = S_RMUL;
      end
      S_RMUL: begin
        cmd.read_mul = 1'b1;
        state_next   = S_RFIN;
      end
      S_RFIN: begin
        cmd.read_finish = 1'b1;
        state_next      = S_DONE;
      end
      S_EFF: begin
        cmd.calc_eff = 1'b1;
        cnt_next     = '0;
        state_next   = status.eff_zero ? S_DONE : S_ST;
      end
      S_ST: begin
        // One window pixel is read per cycle; the final counter value reads nothing and lets the write stage drain.
        cmd.stamp_issue = 1'b1;
        cnt_next        = cnt + 1'b1;
        if (cnt == CNT_W'(PATCH_AREA)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: src/lbsg_datapath.sv
`default_nettype none

module lbsg_datapath #(
  parameter int FRAME_SIDE = lbsg_pkg::FRAME_SIDE_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [lbsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lbsg_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [15:0]                    pixel_index,
  input  wire logic [7:0]                     base_luma,
  input  wire logic [7:0]                     detail_luma,
  input  wire logic [7:0]                     strength,
  input  wire logic [7:0]                     pattern_amp,
  input  wire logic                           sign_negative,
  input  wire logic [7:0]                     center_x,
  input  wire logic [7:0]                     center_y,
  input  wire lbsg_pkg::lbsg_cmd_t            cmd,
  output      lbsg_pkg::lbsg_status_t         status,
  lbsg_result_if.source                       result
);
  import lbsg_pkg::*;

  localparam int FRAME_AREA = FRAME_SIDE * FRAME_SIDE;
  localparam int ADDR_W     = $clog2(FRAME_AREA);

  // Configuration.
  logic [8:0] base_w;
  logic [8:0] detail_w;
  logic [9:0] guidance;

  // Captured item.
  logic [15:0] idx_q;
  logic [7:0]  base_q;
  logic [7:0]  detail_q;
  logic [7:0]  str_q;
  logic [7:0]  amp_q;
  logic        neg_q;
  logic [7:0]  cx_q;
  logic [7:0]  cy_q;

  logic [6:0]         eff_q;
  logic signed [19:0] prod_q;
  logic [7:0]         res_luma;
  logic               res_applied;

  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic [7:0]        s1_weight;

  logic              out_valid;
  logic [7:0]        out_luma;
  logic              out_applied;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              idx_ok;
  logic [ADDR_W-1:0] idx_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_w   <= BASE_GAIN_RESET;
      detail_w <= DETAIL_GAIN_RESET;
      guidance <= GUIDANCE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_GAIN:   base_w   <= cfg_data[8:0];
        REG_DETAIL_GAIN: detail_w <= cfg_data[8:0];
        REG_GUIDANCE:    guidance <= cfg_data;
        default: ;
      endcase
    end
  end

  assign idx_ok   = (32'(idx_q) < FRAME_AREA);
  assign idx_addr = ADDR_W'(idx_q);

  // Blended write.
  logic [17:0] blend_sum;
  logic [9:0]  blend_shr;
  logic [7:0]  blend_val;

  assign blend_sum = 18'(base_w * base_q) + 18'(detail_w * detail_q);
  assign blend_shr = blend_sum[17:8];
  assign blend_val = (blend_shr > 10'(LUMA_MAX)) ? LUMA_MAX : blend_shr[7:0];

  // Effective stamp strength.
  logic [15:0] amp_prod;
  logic [7:0]  eff_raw;
  logic [6:0]  eff_capped;

  assign amp_prod   = str_q * amp_q;
  assign eff_raw    = amp_prod[15:8];
  assign eff_capped = (eff_raw > 8'(EFF_CAP)) ? EFF_CAP : eff_raw[6:0];

  // Window position for the current counter value.
  logic [PATCH_BITS-1:0]     win_r;
  logic [PATCH_BITS-1:0]     win_c;
  logic signed [COORD_W-1:0] win_y;
  logic signed [COORD_W-1:0] win_x;
  logic                      win_inside;
  logic [ADDR_W-1:0]         win_addr;
  logic                      stamp_rd;

  assign win_r = cmd.cnt[2*PATCH_BITS-1:PATCH_BITS];
  assign win_c = cmd.cnt[PATCH_BITS-1:0];
  assign win_y = signed'(COORD_W'(cy_q)) + signed'(COORD_W'(win_r))
               - signed'(COORD_W'(PATCH_HALF));
  assign win_x = signed'(COORD_W'(cx_q)) + signed'(COORD_W'(win_c))
               - signed'(COORD_W'(PATCH_HALF));
  assign win_inside = !win_y[COORD_W-1] && !win_x[COORD_W-1]
                   && (int'(win_y) < FRAME_SIDE) && (int'(win_x) < FRAME_SIDE);
  assign win_addr = ADDR_W'(int'(win_y) * FRAME_SIDE + int'(win_x));
  assign stamp_rd = cmd.stamp_issue && !cmd.cnt[CNT_W-1] && win_inside;

  // Modify stage of the stamp: the pixel read last cycle is adjusted and written back.
  logic [14:0] delta_prod;
  logic [7:0]  delta;
  logic [8:0]  stamp_sum;
  logic [7:0]  stamp_val;

  assign delta_prod = eff_q * s1_weight;
  assign delta      = {1'b0, delta_prod[14:8]};
  assign stamp_sum  = {1'b0, ram_rdata} + {1'b0, delta};

  always_comb begin
    if (neg_q) begin
      stamp_val = (ram_rdata < delta) ? '0 : ram_rdata - delta;
    end else begin
      stamp_val = stamp_sum[8] ? LUMA_MAX : stamp_sum[7:0];
    end
  end

  // Guided read.
  logic signed [8:0]  rd_dev;
  logic signed [19:0] rd_prod;
  logic signed [19:0] rd_quot;
  logic signed [19:0] rd_val;
  logic [7:0]         rd_clamped;

  assign rd_dev  = signed'({1'b0, ram_rdata}) - signed'({1'b0, LUMA_MID});
  assign rd_prod = signed'({1'b0, guidance}) * rd_dev;
  // The divide by 256 truncates toward zero, so negative products are biased first.
  assign rd_quot = prod_q[19] ? ((prod_q + 20'sd255) >>> 8) : (prod_q >>> 8);
  assign rd_val  = rd_quot + signed'(20'(LUMA_MID));

  always_comb begin
    if (rd_val < 0) begin
      rd_clamped = '0;
    end else if (rd_val > signed'(20'(LUMA_MAX))) begin
      rd_clamped = LUMA_MAX;
    end else begin
      rd_clamped = rd_val[7:0];
    end
  end

  // Frame memory ports.
  assign ram_we    = (cmd.write_blend && idx_ok) || s1_valid;
  assign ram_waddr = s1_valid ? s1_addr : idx_addr;
  assign ram_wdata = s1_valid ? stamp_val : blend_val;
  assign ram_re    = (cmd.read_issue && idx_ok) || stamp_rd;
  assign ram_raddr = cmd.read_issue ? idx_addr : win_addr;

  lbsg_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_AREA)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      idx_q    <= pixel_index;
      base_q   <= base_luma;
      detail_q <= detail_luma;
      str_q    <= strength;
      amp_q    <= pattern_amp;
      neg_q    <= sign_negative;
      cx_q     <= center_x;
      cy_q     <= center_y;
    end
    if (cmd.calc_eff) begin
      eff_q <= eff_capped;
    end
    if (cmd.read_mul) begin
      prod_q <= rd_prod;
    end
    s1_addr   <= win_addr;
    s1_weight <= PATCH_WEIGHT[cmd.cnt[CNT_W-2:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      res_luma    <= '0;
      res_applied <= 1'b0;
      out_valid   <= 1'b0;
      out_luma    <= '0;
      out_applied <= 1'b0;
    end else begin
      s1_valid <= stamp_rd;
      if (cmd.load_item) begin
        res_luma    <= '0;
        res_applied <= 1'b0;
      end
      if (cmd.calc_eff) begin
        res_applied <= (eff_raw != '0);
      end
      if (cmd.read_finish) begin
        res_luma <= idx_ok ? rd_clamped : '0;
      end
      if (cmd.load_result) begin
        out_valid   <= 1'b1;
        out_luma    <= res_luma;
        out_applied <= res_applied;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.eff_zero = (eff_raw == '0);
  assign status.out_free = !out_valid || result.ready;

  assign result.valid         = out_valid;
  assign result.read_luma     = out_luma;
  assign result.stamp_applied = out_applied;

endmodule

`default_nettype wire

// File: src/luma_blend_stamp_guidance_core.sv
`default_nettype none

// Channel   Role    Handshake      Payload
// item      sink    valid/ready    command, pixel_index, blend samples, stamp fields
// result    source  valid/ready    read_luma, stamp_applied
// cfg       write   cfg_write      cfg_index, cfg_data (no read-back)
//
// One transaction at a time.
// A stamp visits its 64 window pixels at one per cycle through the frame memory's
// read port, with each write-back in the cycle after its read on the write port.
// Reset is synchronous; the frame memory is not cleared and must be written before use.
// A new item is taken while a result still waits on a stalled result channel.

module luma_blend_stamp_guidance_core #(
  parameter int FRAME_SIDE = lbsg_pkg::FRAME_SIDE_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  lbsg_item_if.sink                           item,
  lbsg_result_if.source                       result,
  input  wire logic                           cfg_write,
  input  wire logic [lbsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lbsg_pkg::CFG_W-1:0]     cfg_data
);
  import lbsg_pkg::*;

  lbsg_cmd_t    cmd;
  lbsg_status_t status;

  lbsg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_command (item.command),
    .item_ready   (item.ready),
    .cmd          (cmd),
    .status       (status)
  );

  lbsg_datapath #(
    .FRAME_SIDE (FRAME_SIDE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_index   (item.pixel_index),
    .base_luma     (item.base_luma),
    .detail_luma   (item.detail_luma),
    .strength      (item.strength),
    .pattern_amp   (item.pattern_amp),
    .sign_negative (item.sign_negative),
    .center_x      (item.center_x),
    .center_y      (item.center_y),
    .cmd           (cmd),
    .status        (status),
    .result        (result)
  );

  // Every transaction keeps the controller busy in the cycle after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item accepted on consecutive cycles");

  // Only a read carries a luma value and only a stamp can report application.
  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.stamp_applied && (result.read_luma != 8'd0)))
    else $error("result carries both read and stamp outcome");

  // The output register is never overwritten while a result is still pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> status.out_free)
    else $error("result register overwritten");

endmodule

`default_nettype wire

// File: sim/tb_luma_blend_stamp_guidance_core.sv
`default_nettype none

module tb_luma_blend_stamp_guidance_core;
  import lbsg_pkg::*;

  localparam int FRAME_SIDE = 256;
  localparam int FRAME_AREA = FRAME_SIDE * FRAME_SIDE;
  localparam int STAMP_EFF_CAP = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1500;
  localparam int OPS_PER_EPISODE = 50;
  localparam int RESULT_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT = 4000;

  // Stamp weights, row by row from the top-left corner of the window.
  localparam logic [7:0] STAMP_WEIGHT [64] = '{
    8'd16, 8'd32,  8'd48,  8'd64,  8'd64,  8'd48,  8'd32,  8'd16,
    8'd32, 8'd64,  8'd96,  8'd128, 8'd128, 8'd96,  8'd64,  8'd32,
    8'd48, 8'd96,  8'd144, 8'd192, 8'd192, 8'd144, 8'd96,  8'd48,
    8'd64, 8'd128, 8'd192, 8'd255, 8'd255, 8'd192, 8'd128, 8'd64,
    8'd64, 8'd128, 8'd192, 8'd255, 8'd255, 8'd192, 8'd128, 8'd64,
    8'd48, 8'd96,  8'd144, 8'd192, 8'd192, 8'd144, 8'd96,  8'd48,
    8'd32, 8'd64,  8'd96,  8'd128, 8'd128, 8'd96,  8'd64,  8'd32,
    8'd16, 8'd32,  8'd48,  8'd64,  8'd64,  8'd48,  8'd32,  8'd16
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] pixel_index;
    logic [7:0]  base_luma;
    logic [7:0]  detail_luma;
    logic [7:0]  strength;
    logic [7:0]  pattern_amp;
    logic        sign_negative;
    logic [7:0]  center_x;
    logic [7:0]  center_y;
  } luma_item_t;

  typedef struct packed {
    logic [7:0] read_luma;
    logic       stamp_applied;
  } luma_result_t;

  typedef struct {
    luma_item_t   stim;
    bit           typed;
    luma_result_t want;
  } probe_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lbsg_item_if   item_ch ();
  lbsg_result_if result_ch ();

  luma_blend_stamp_guidance_core #(
    .FRAME_SIDE(FRAME_SIDE)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Mirror of the frame, advanced at every accepted transaction, and of the settings.
  logic [7:0]   frame_mirror [FRAME_AREA];
  bit           written_map [FRAME_AREA];
  logic [8:0]   base_gain = BASE_GAIN_RESET;
  logic [8:0]   detail_gain = DETAIL_GAIN_RESET;
  logic [9:0]   guidance_gain = GUIDANCE_RESET;
  luma_result_t pending_results [$];

  int mismatches = 0;
  int burst_left = 0;
  bit offering = 1'b0;
  bit hold_wanted = 1'b0;

  always #5 clk = ~clk;

  function automatic logic [7:0] clamp_luma(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  function automatic luma_result_t predict_luma_result(input luma_item_t it);
    luma_result_t res;
    int           idx;
    int           eff;
    int           yy;
    int           xx;
    int           delta;
    res = '0;
    idx = int'(it.pixel_index);
    case (it.command)
      CMD_WRITE: begin
        frame_mirror[idx] = clamp_luma((int'(base_gain) * int'(it.base_luma)
                                        + int'(detail_gain) * int'(it.detail_luma)) >> 8);
      end
      CMD_STAMP: begin
        eff = (int'(it.strength) * int'(it.pattern_amp)) >> 8;
        if (eff > STAMP_EFF_CAP) begin
          eff = STAMP_EFF_CAP;
        end
        if (eff != 0) begin
          res.stamp_applied = 1'b1;
          for (int r = 0; r < PATCH_SIDE; r++) begin
            for (int c = 0; c < PATCH_SIDE; c++) begin
              yy = int'(it.center_y) + r - PATCH_HALF;
              xx = int'(it.center_x) + c - PATCH_HALF;
              if (yy >= 0 && yy < FRAME_SIDE && xx >= 0 && xx < FRAME_SIDE) begin
                delta = (eff * int'(STAMP_WEIGHT[r * PATCH_SIDE + c])) >> 8;
                if (it.sign_negative) begin
                  delta = -delta;
                end
                frame_mirror[yy * FRAME_SIDE + xx] =
                  clamp_luma(int'(frame_mirror[yy * FRAME_SIDE + xx]) + delta);
              end
            end
          end
        end
      end
      CMD_READ: begin
        // Signed division in SystemVerilog truncates toward zero.
        res.read_luma = clamp_luma(128 + (int'(guidance_gain)
                                          * (int'(frame_mirror[idx]) - 128)) / 256);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic bit window_ready(input int cx, input int cy);
    int yy;
    int xx;
    for (int r = 0; r < PATCH_SIDE; r++) begin
      for (int c = 0; c < PATCH_SIDE; c++) begin
        yy = cy + r - PATCH_HALF;
        xx = cx + c - PATCH_HALF;
        if (yy >= 0 && yy < FRAME_SIDE && xx >= 0 && xx < FRAME_SIDE &&
            !written_map[yy * FRAME_SIDE + xx]) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic luma_item_t random_item();
    luma_item_t it;
    it.command       = 2'($urandom_range(0, 3));
    it.pixel_index   = 16'($urandom_range(0, 65535));
    it.base_luma     = 8'($urandom_range(0, 255));
    it.detail_luma   = 8'($urandom_range(0, 255));
    it.strength      = 8'($urandom_range(0, 255));
    it.pattern_amp   = 8'($urandom_range(0, 255));
    it.sign_negative = 1'($urandom_range(0, 1));
    it.center_x      = 8'($urandom_range(0, 255));
    it.center_y      = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic probe_row_t probe(input logic [1:0] cmd, input logic [15:0] idx,
                                       input logic [7:0] b, input logic [7:0] d,
                                       input logic [7:0] s, input logic [7:0] a,
                                       input logic neg, input logic [7:0] cx,
                                       input logic [7:0] cy, input bit typed,
                                       input logic [7:0] luma, input logic applied);
    probe_row_t row;
    row.stim  = '{cmd, idx, b, d, s, a, neg, cx, cy};
    row.typed = typed;
    row.want  = '{luma, applied};
    return row;
  endfunction

  // The sender offers items in bursts; valid stays high across a burst.
  task automatic offer_luma_item(input luma_item_t it, input bit typed,
                                 input luma_result_t want);
    luma_result_t got;
    if (burst_left == 0) begin
      if (offering) begin
        item_ch.valid <= 1'b0;
        offering = 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : int'($urandom_range(1, 20));
    end
    item_ch.valid         <= 1'b1;
    offering = 1'b1;
    item_ch.command       <= it.command;
    item_ch.pixel_index   <= it.pixel_index;
    item_ch.base_luma     <= it.base_luma;
    item_ch.detail_luma   <= it.detail_luma;
    item_ch.strength      <= it.strength;
    item_ch.pattern_amp   <= it.pattern_amp;
    item_ch.sign_negative <= it.sign_negative;
    item_ch.center_x      <= it.center_x;
    item_ch.center_y      <= it.center_y;
    do @(posedge clk); while (!item_ch.ready);
    burst_left--;
    got = predict_luma_result(it);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic wait_results_drained();
    if (offering) begin
      item_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apply_luma_settings(input logic [8:0] b, input logic [8:0] d,
                                     input logic [9:0] g);
    wait_results_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_BASE_GAIN;
    cfg_data  <= CFG_W'(b);
    @(posedge clk);
    cfg_index <= REG_DETAIL_GAIN;
    cfg_data  <= CFG_W'(d);
    @(posedge clk);
    cfg_index <= REG_GUIDANCE;
    cfg_data  <= g;
    @(posedge clk);
    cfg_write <= 1'b0;
    base_gain     = b;
    detail_gain   = d;
    guidance_gain = g;
  endtask

  always @(posedge clk) begin : result_check
    luma_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: read_luma %0d stamp_applied %0d",
               result_ch.read_luma, result_ch.stamp_applied);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.read_luma !== want.read_luma) begin
          $error("read_luma: expected %0d, actual %0d", want.read_luma, result_ch.read_luma);
          mismatches++;
        end
        if (result_ch.stamp_applied !== want.stamp_applied) begin
          $error("stamp_applied: expected %0d, actual %0d",
                 want.stamp_applied, result_ch.stamp_applied);
          mismatches++;
        end
      end
    end
  end

  // The receiver changes its stall pattern every segment and, when asked, holds off
  // long enough for the core to back up onto its input.
  initial begin : result_stall_pattern
    int mode;
    int span;
    int tick;
    tick = 0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (RESULT_HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(0, 1));
          2: result_ch.ready <= ($urandom_range(0, 7) != 0);
          default: result_ch.ready <= ((tick % 16) < 11);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no transaction for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    probe_row_t   probes [$];
    luma_item_t   it;
    luma_result_t none;
    int           counted;
    int           episode;
    int           anchor_x;
    int           anchor_y;
    int           cx;
    int           cy;
    int           k;
    logic [7:0]   b;
    logic [7:0]   d;

    none = '0;
    item_ch.valid         <= 1'b0;
    item_ch.command       <= CMD_WRITE;
    item_ch.pixel_index   <= '0;
    item_ch.base_luma     <= '0;
    item_ch.detail_luma   <= '0;
    item_ch.strength      <= '0;
    item_ch.pattern_amp   <= '0;
    item_ch.sign_negative <= 1'b0;
    item_ch.center_x      <= '0;
    item_ch.center_y      <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_BASE_GAIN;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset weights. The bottom-right 4x4 corner is the
    // whole in-frame window of a stamp centred on the last pixel.
    probes.push_back(probe(CMD_WRITE, 16'd0, 8'd255, 8'd255, 0, 0, 0, 0, 0, 1, 0, 0));
    written_map[0] = 1'b1;
    for (int r = 252; r < FRAME_SIDE; r++) begin
      for (int c = 252; c < FRAME_SIDE; c++) begin
        b = (r == 255 && c == 255) ? 8'd0 : 8'((r - 252) * 85);
        d = (r == 255 && c == 255) ? 8'd0 : 8'((c - 252) * 85);
        probes.push_back(probe(CMD_WRITE, 16'(r * FRAME_SIDE + c), b, d,
                               0, 0, 0, 0, 0, 1, 0, 0));
        written_map[r * FRAME_SIDE + c] = 1'b1;
      end
    end
    probes.push_back(probe(CMD_READ, 16'd0, 0, 0, 0, 0, 0, 0, 0, 1, 8'd255, 0));
    probes.push_back(probe(CMD_READ, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 1, 8'd0, 0));
    probes.push_back(probe(CMD_UNUSED, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255, 1,
                           8'd255, 8'd255, 1, 0, 0));
    probes.push_back(probe(CMD_STAMP, 16'hFFFF, 0, 0, 8'd255, 8'd0, 1, 0, 0, 1, 0, 0));
    probes.push_back(probe(CMD_STAMP, 16'd0, 0, 0, 8'd15, 8'd17, 0, 8'd128, 8'd128,
                           1, 0, 0));
    // Full strength downward into the corner: pixels that would go below zero clamp at zero.
    probes.push_back(probe(CMD_STAMP, 16'd0, 0, 0, 8'd255, 8'd255, 1, 8'd255, 8'd255,
                           1, 0, 1));
    // Effective strength of one leaves every pixel as it was, yet still counts.
    probes.push_back(probe(CMD_STAMP, 16'd0, 0, 0, 8'd16, 8'd16, 0, 8'd255, 8'd255,
                           1, 0, 1));
    probes.push_back(probe(CMD_STAMP, 16'd0, 0, 0, 8'd255, 8'd255, 0, 8'd255, 8'd255,
                           1, 0, 1));
    probes.push_back(probe(CMD_READ, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    probes.push_back(probe(CMD_READ, 16'(253 * FRAME_SIDE + 254), 0, 0, 0, 0, 0, 0, 0,
                           0, 0, 0));
    probes.push_back(probe(CMD_READ, 16'(252 * FRAME_SIDE + 252), 0, 0, 0, 0, 0, 0, 0,
                           0, 0, 0));
    foreach (probes[i]) begin
      offer_luma_item(probes[i].stim, probes[i].typed, probes[i].want);
    end

    // Random part: each episode fills the window around an anchor, then works on it.
    counted = 0;
    episode = 0;
    while (counted < RANDOM_ITEMS) begin
      if (episode % 2 == 0) begin
        case (episode / 2)
          0: apply_luma_settings(9'd0, 9'd0, 10'd0);
          1: apply_luma_settings(9'd256, 9'd256, 10'd1023);
          2: apply_luma_settings(9'd256, 9'd0, 10'd1);
          3: apply_luma_settings(9'd0, 9'd256, 10'd512);
          default: apply_luma_settings(9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)),
                                       10'($urandom_range(0, 1023)));
        endcase
      end
      if (episode == 1 || episode == 6) begin
        hold_wanted = 1'b1;
      end
      case (episode)
        0: begin anchor_x = 0;   anchor_y = 0;   end
        1: begin anchor_x = 255; anchor_y = 0;   end
        2: begin anchor_x = 0;   anchor_y = 255; end
        default: begin
          anchor_x = $urandom_range(0, 255);
          anchor_y = $urandom_range(0, 255);
        end
      endcase

      for (int r = 0; r < PATCH_SIDE; r++) begin
        for (int c = 0; c < PATCH_SIDE; c++) begin
          cy = anchor_y + r - PATCH_HALF;
          cx = anchor_x + c - PATCH_HALF;
          if (cy >= 0 && cy < FRAME_SIDE && cx >= 0 && cx < FRAME_SIDE) begin
            it = random_item();
            it.command     = CMD_WRITE;
            it.pixel_index = 16'(cy * FRAME_SIDE + cx);
            it.base_luma   = pick_sample();
            it.detail_luma = pick_sample();
            written_map[cy * FRAME_SIDE + cx] = 1'b1;
            offer_luma_item(it, 1'b0, none);
            counted++;
          end
        end
      end

      for (int op = 0; op < OPS_PER_EPISODE; op++) begin
        it = random_item();
        k = $urandom_range(0, 99);
        if (k < 25 || (k >= 55 && k < 85)) begin
          do begin
            cx = anchor_x + int'($urandom_range(0, 7)) - PATCH_HALF;
            cy = anchor_y + int'($urandom_range(0, 7)) - PATCH_HALF;
          end while (cx < 0 || cx >= FRAME_SIDE || cy < 0 || cy >= FRAME_SIDE);
          it.command     = (k < 25) ? CMD_WRITE : CMD_READ;
          it.pixel_index = 16'(cy * FRAME_SIDE + cx);
          it.base_luma   = pick_sample();
          it.detail_luma = pick_sample();
        end else if (k < 55) begin
          cx = anchor_x + int'($urandom_range(0, 2)) - 1;
          cy = anchor_y + int'($urandom_range(0, 2)) - 1;
          if (cx < 0 || cx >= FRAME_SIDE || cy < 0 || cy >= FRAME_SIDE ||
              !window_ready(cx, cy)) begin
            cx = anchor_x;
            cy = anchor_y;
          end
          it.command  = CMD_STAMP;
          it.center_x = 8'(cx);
          it.center_y = 8'(cy);
          case ($urandom_range(0, 9))
            0: begin
              it.strength    = 8'd16;
              it.pattern_amp = 8'($urandom_range(16, 31));
            end
            1: begin
              it.strength    = 8'd255;
              it.pattern_amp = 8'd255;
            end
            2: it.pattern_amp = 8'd0;
            default: begin
            end
          endcase
        end else if (k < 92) begin
          it.command = CMD_UNUSED;
        end else begin
          // A stamp that is skipped touches no pixel, so any centre will do.
          it.command     = CMD_STAMP;
          it.pattern_amp = (it.strength == 8'd0) ? it.pattern_amp
                                                 : 8'($urandom_range(0, 255 / int'(it.strength)));
        end
        offer_luma_item(it, 1'b0, none);
        counted++;
      end
      episode++;
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
